// ===== rtl/fg_pkg.sv =====
// ----------------------------------------------------------------------------
// Fuel gauge package
// Shared widths, constants, item types and unit command types of the gauge.
// ----------------------------------------------------------------------------
`default_nettype none

package fg_pkg;

  localparam int FULL_SCALE      = 100;
  localparam int FRACTION_SCALE  = 10000;
  localparam int FS_EFF          = (FRACTION_SCALE == 0) ? 1 : FRACTION_SCALE;
  localparam int SCALE           = FULL_SCALE * FS_EFF;
  localparam int SCALE_W         = $clog2(SCALE + 1);

  localparam int MS_PER_SECOND   = 1000;
  localparam int SLACK_DIV       = 10;

  localparam int CNT_W           = 32;
  localparam int CUR_W           = 16;
  localparam int TPS_W           = 21;
  localparam int PERIOD_W        = 22;
  localparam int CHARGE_W        = 48;
  localparam int PCT_W           = 7;
  localparam int FRAC_W          = 14;

  localparam int MS_W            = CNT_W + $clog2(MS_PER_SECOND);
  localparam int DIV_W           = CHARGE_W;
  localparam int DVD_W           = MS_W;
  localparam int STEP_W          = $clog2(DVD_W + 1);
  localparam int MCAND_W         = CHARGE_W;
  localparam int MPLR_W          = (CUR_W > SCALE_W) ? CUR_W : SCALE_W;
  localparam int ACC_W           = MCAND_W + MPLR_W;
  localparam int MUL_CNT_W       = $clog2(MPLR_W);

  localparam int NUM_LANES       = 4;
  localparam int LANE_W          = 2;
  localparam logic [LANE_W-1:0] LANE_LAST = LANE_W'(NUM_LANES - 1);

  localparam logic [TPS_W-1:0]    RST_TPS         = TPS_W'(32768);
  localparam logic [PERIOD_W-1:0] RST_PERIOD      = PERIOD_W'(60000);
  localparam logic [CHARGE_W-1:0] RST_FULL_CHARGE = CHARGE_W'(64'd120000000000);

  typedef enum logic [2:0] {
    CFG_MAIN_POWERED      = 3'd0,
    CFG_CURRENT_CPU       = 3'd1,
    CFG_CURRENT_LOW_POWER = 3'd2,
    CFG_CURRENT_TRANSMIT  = 3'd3,
    CFG_CURRENT_LISTEN    = 3'd4,
    CFG_TICKS_PER_SECOND  = 3'd5,
    CFG_PERIOD_MS         = 3'd6,
    CFG_FULL_CHARGE       = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [CNT_W-1:0] cpu_ticks;
    logic [CNT_W-1:0] low_power_ticks;
    logic [CNT_W-1:0] transmit_ticks;
    logic [CNT_W-1:0] listen_ticks;
  } in_item_t;

  typedef struct packed {
    logic [PCT_W-1:0]  charge_percent;
    logic [FRAC_W-1:0] charge_fraction;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_cmd_t;

  typedef struct packed {
    logic start;
    logic clear;
  } mul_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/fg_sdiv.sv =====
// ----------------------------------------------------------------------------
// Fuel gauge serial divider
// Restoring divider that retires one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module fg_sdiv (
  input  logic                       clk,
  input  logic                       rst_n,
  input  fg_pkg::div_cmd_t           cmd,
  input  logic [fg_pkg::DIV_W-1:0]   init_rem,
  input  logic [fg_pkg::DVD_W-1:0]   dividend,
  input  logic [fg_pkg::DIV_W-1:0]   divisor,
  output logic                       done,
  output logic [fg_pkg::DVD_W-1:0]   quo,
  output logic [fg_pkg::DIV_W-1:0]   rem
);
  import fg_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [STEP_W-1:0] stop_r;
  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W-1:0]  rem_nxt;
  logic [DVD_W-1:0]  dvd_r;
  logic [DVD_W-1:0]  quo_r;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;
  logic              fits;

  always_comb begin
    trial   = {rem_r, dvd_r[DVD_W-1]};
    diff    = trial - {1'b0, divisor};
    fits    = (trial >= {1'b0, divisor});
    rem_nxt = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == stop_r) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem_r  <= init_rem;
      dvd_r  <= dividend;
      quo_r  <= '0;
      stop_r <= STEP_W'(cmd.steps - 1'b1);
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      quo_r <= {quo_r[DVD_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

// ===== rtl/fg_smul.sv =====
// ----------------------------------------------------------------------------
// Fuel gauge serial multiplier
// Shift-and-add multiplier, one multiplier bit per cycle, LSB first. The
// accumulator can be kept across products to form a sum of products.
// ----------------------------------------------------------------------------
`default_nettype none

module fg_smul (
  input  logic                       clk,
  input  logic                       rst_n,
  input  fg_pkg::mul_cmd_t           cmd,
  input  logic [fg_pkg::MCAND_W-1:0] mcand,
  input  logic [fg_pkg::MPLR_W-1:0]  mplier,
  output logic                       done,
  output logic [fg_pkg::ACC_W-1:0]   acc
);
  import fg_pkg::*;

  localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(MPLR_W - 1);

  logic                 busy_r;
  logic                 done_r;
  logic [MUL_CNT_W-1:0] cnt_r;
  logic [ACC_W-1:0]     a_r;
  logic [MPLR_W-1:0]    b_r;
  logic [ACC_W-1:0]     acc_r;
  logic [ACC_W-1:0]     acc_nxt;

  assign acc_nxt = b_r[0] ? (acc_r + a_r) : acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == MUL_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      a_r <= ACC_W'(mcand);
      b_r <= mplier;
      if (cmd.clear) begin
        acc_r <= '0;
      end
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      a_r   <= {a_r[ACC_W-2:0], 1'b0};
      b_r   <= {1'b0, b_r[MPLR_W-1:1]};
    end
  end

  assign done = done_r;
  assign acc  = acc_r;

endmodule

`default_nettype wire

// ===== rtl/coulomb_counting_fuel_gauge_top.sv =====
// ----------------------------------------------------------------------------
// Coulomb-counting battery fuel gauge, top level.
// On battery an item runs through the four divider lanes, the serial multiplier for the drain
// products and the scaling product, and lane 0 for the ratio and percent split, with the fix,
// subtract, check and done steps between; a zero full charge or a full gauge skips some.
// On mains power an item goes straight to done. A new item is accepted only once the last
// result is loaded. Reset is synchronous and restores all defaults at once.
// ----------------------------------------------------------------------------
`default_nettype none

module coulomb_counting_fuel_gauge_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  fg_pkg::in_item_t            in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output fg_pkg::out_item_t           out_data,
  input  logic                        cfg_we,
  input  fg_pkg::cfg_idx_t            cfg_index,
  input  logic [fg_pkg::CHARGE_W-1:0] cfg_wdata
);
  import fg_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_CONV  = 10'b0000000010,
    ST_FIX   = 10'b0000000100,
    ST_MUL   = 10'b0000001000,
    ST_SUB   = 10'b0000010000,
    ST_CHK   = 10'b0000100000,
    ST_SCALE = 10'b0001000000,
    ST_RATIO = 10'b0010000000,
    ST_SPLIT = 10'b0100000000,
    ST_DONE  = 10'b1000000000
  } state_t;

  state_t               state_r;
  state_t               state_nxt;
  logic [LANE_W-1:0]    idx_r;

  logic                 main_powered_r;
  logic [CUR_W-1:0]     cur_r [NUM_LANES];
  logic [TPS_W-1:0]     tps_r;
  logic [PERIOD_W-1:0]  period_r;
  logic [CHARGE_W-1:0]  full_r;
  logic [CHARGE_W-1:0]  rem_r;
  logic [CHARGE_W-1:0]  rem_nxt;
  logic [CNT_W-1:0]     last_r [NUM_LANES];
  logic [FRAC_W-1:0]    held_r;
  logic [MS_W-1:0]      ms_r [NUM_LANES];
  out_item_t            res_r;
  out_item_t            out_data_r;
  logic                 out_valid_r;

  logic                 accept;
  logic                 conv_start;
  logic [CNT_W-1:0]     cnt_in [NUM_LANES];
  logic [DVD_W-1:0]     conv_dvd [NUM_LANES];
  logic [TPS_W-1:0]     tps_eff;

  div_cmd_t             div0_cmd;
  div_cmd_t             conv_cmd;
  logic [DIV_W-1:0]     div0_init;
  logic [DVD_W-1:0]     div0_dvd;
  logic [DIV_W-1:0]     div0_dsr;
  logic                 div0_done;
  logic [DIV_W-1:0]     div0_rem;
  logic [DVD_W-1:0]     lane_quo [NUM_LANES];

  mul_cmd_t             mul_cmd;
  logic [LANE_W-1:0]    mul_sel;
  logic [MCAND_W-1:0]   mul_mcand;
  logic [MPLR_W-1:0]    mul_mplier;
  logic                 mul_done;
  logic [ACC_W-1:0]     mul_acc;

  logic [MS_W+1:0]      busy_sum;
  logic [MS_W+3:0]      lpm_x10;
  logic [MS_W+3:0]      lim_x11;
  logic                 implaus;
  logic [MS_W-1:0]      lpm_fix;
  logic [CHARGE_W-1:0]  rem_sub;
  logic                 full_zero;
  logic                 chk_split;
  logic                 chk_scale;
  logic                 out_load;

  assign in_ready   = (state_r == ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign conv_start = accept && !main_powered_r;

  assign cnt_in[0] = in_data.cpu_ticks;
  assign cnt_in[1] = in_data.low_power_ticks;
  assign cnt_in[2] = in_data.transmit_ticks;
  assign cnt_in[3] = in_data.listen_ticks;

  assign tps_eff = (tps_r == '0) ? TPS_W'(1) : tps_r;

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      conv_dvd[i] = DVD_W'(CNT_W'(cnt_in[i] - last_r[i])) * DVD_W'(MS_PER_SECOND);
    end
  end

  assign conv_cmd.start = conv_start;
  assign conv_cmd.steps = STEP_W'(DVD_W);

  assign full_zero = (full_r == '0);
  assign chk_split = !full_zero && (rem_r >= full_r);
  assign chk_scale = !full_zero && (rem_r < full_r);

  // Lane 0 also runs the charge ratio and the percent split.
  always_comb begin
    div0_cmd  = conv_cmd;
    div0_init = '0;
    div0_dvd  = conv_dvd[0];
    div0_dsr  = DIV_W'(tps_eff);
    case (state_r)
      ST_CHK: begin
        div0_cmd.start = chk_split;
        div0_cmd.steps = STEP_W'(SCALE_W);
        div0_dvd       = {SCALE_W'(SCALE), {(DVD_W - SCALE_W){1'b0}}};
      end
      ST_SCALE: begin
        div0_cmd.start = mul_done;
        div0_cmd.steps = STEP_W'(SCALE_W);
        div0_init      = mul_acc[SCALE_W +: CHARGE_W];
        div0_dvd       = {mul_acc[SCALE_W-1:0], {(DVD_W - SCALE_W){1'b0}}};
      end
      ST_RATIO: begin
        div0_cmd.start = div0_done;
        div0_cmd.steps = STEP_W'(SCALE_W);
        div0_dvd       = {lane_quo[0][SCALE_W-1:0], {(DVD_W - SCALE_W){1'b0}}};
        div0_dsr       = full_r;
      end
      ST_SPLIT: begin
        div0_dsr = DIV_W'(FS_EFF);
      end
      default: begin
      end
    endcase
  end

  fg_sdiv u_div0 (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (div0_cmd),
    .init_rem (div0_init),
    .dividend (div0_dvd),
    .divisor  (div0_dsr),
    .done     (div0_done),
    .quo      (lane_quo[0]),
    .rem      (div0_rem)
  );

  for (genvar g = 1; g < NUM_LANES; g++) begin : g_lane
    fg_sdiv u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (conv_cmd),
      .init_rem ('0),
      .dividend (conv_dvd[g]),
      .divisor  (DIV_W'(tps_eff)),
      .done     (),
      .quo      (lane_quo[g]),
      .rem      ()
    );
  end

  always_comb begin
    mul_sel       = (state_r == ST_MUL) ? LANE_W'(idx_r + 1'b1) : '0;
    mul_cmd.start = (state_r == ST_FIX)
                 || ((state_r == ST_MUL) && mul_done && (idx_r != LANE_LAST))
                 || ((state_r == ST_CHK) && chk_scale);
    mul_cmd.clear = (state_r != ST_MUL);
    mul_mcand     = (state_r == ST_CHK) ? rem_r : MCAND_W'(ms_r[mul_sel]);
    mul_mplier    = (state_r == ST_CHK) ? MPLR_W'(SCALE) : MPLR_W'(cur_r[mul_sel]);
  end

  fg_smul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (mul_cmd),
    .mcand  (mul_mcand),
    .mplier (mul_mplier),
    .done   (mul_done),
    .acc    (mul_acc)
  );

  // The low-power time is implausible when it exceeds the period plus a tenth,
  // which is the same as ten times it exceeding eleven periods.
  always_comb begin
    busy_sum = (MS_W+2)'(ms_r[0]) + (MS_W+2)'(ms_r[2]) + (MS_W+2)'(ms_r[3]);
    lpm_x10  = (MS_W+4)'(ms_r[1]) * (MS_W+4)'(SLACK_DIV);
    lim_x11  = (MS_W+4)'(period_r) * (MS_W+4)'(SLACK_DIV + 1);
    implaus  = (lpm_x10 > lim_x11);
    lpm_fix  = (busy_sum >= (MS_W+2)'(period_r)) ? '0 :
               MS_W'(period_r - busy_sum[PERIOD_W-1:0]);
    rem_sub  = (mul_acc >= ACC_W'(rem_r)) ? '0 : (rem_r - mul_acc[CHARGE_W-1:0]);
  end

  always_comb begin
    rem_nxt = rem_r;
    if (cfg_we && (cfg_index == CFG_FULL_CHARGE)) begin
      rem_nxt = cfg_wdata;
    end else if (state_r == ST_SUB) begin
      rem_nxt = rem_sub;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = main_powered_r ? ST_DONE : ST_CONV;
        end
      end
      ST_CONV: begin
        if (div0_done) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (mul_done && (idx_r == LANE_LAST)) begin
          state_nxt = ST_SUB;
        end
      end
      ST_SUB: begin
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (full_zero) begin
          state_nxt = ST_DONE;
        end else if (chk_split) begin
          state_nxt = ST_SPLIT;
        end else begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (mul_done) begin
          state_nxt = ST_RATIO;
        end
      end
      ST_RATIO: begin
        if (div0_done) begin
          state_nxt = ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        if (div0_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      idx_r          <= '0;
      main_powered_r <= 1'b0;
      for (int i = 0; i < NUM_LANES; i++) begin
        cur_r[i]  <= '0;
        last_r[i] <= '0;
      end
      tps_r          <= RST_TPS;
      period_r       <= RST_PERIOD;
      full_r         <= RST_FULL_CHARGE;
      rem_r          <= RST_FULL_CHARGE;
      held_r         <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rem_r   <= rem_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAIN_POWERED:      main_powered_r <= cfg_wdata[0];
          CFG_CURRENT_CPU:       cur_r[0]       <= cfg_wdata[CUR_W-1:0];
          CFG_CURRENT_LOW_POWER: cur_r[1]       <= cfg_wdata[CUR_W-1:0];
          CFG_CURRENT_TRANSMIT:  cur_r[2]       <= cfg_wdata[CUR_W-1:0];
          CFG_CURRENT_LISTEN:    cur_r[3]       <= cfg_wdata[CUR_W-1:0];
          CFG_TICKS_PER_SECOND:  tps_r          <= cfg_wdata[TPS_W-1:0];
          CFG_PERIOD_MS:         period_r       <= cfg_wdata[PERIOD_W-1:0];
          CFG_FULL_CHARGE:       full_r         <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (conv_start) begin
        for (int i = 0; i < NUM_LANES; i++) begin
          last_r[i] <= cnt_in[i];
        end
      end
      if (state_r == ST_FIX) begin
        idx_r <= '0;
      end else if ((state_r == ST_MUL) && mul_done) begin
        idx_r <= idx_r + 1'b1;
      end
      if ((state_r == ST_CHK) && full_zero) begin
        held_r <= '0;
      end else if ((state_r == ST_SPLIT) && div0_done) begin
        held_r <= div0_rem[FRAC_W-1:0];
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_CONV) && div0_done) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        ms_r[i] <= lane_quo[i];
      end
    end else if ((state_r == ST_FIX) && implaus) begin
      ms_r[1] <= lpm_fix;
    end
    if (accept && main_powered_r) begin
      res_r.charge_percent  <= PCT_W'(FULL_SCALE);
      res_r.charge_fraction <= held_r;
    end else if ((state_r == ST_CHK) && full_zero) begin
      res_r <= '0;
    end else if ((state_r == ST_SPLIT) && div0_done) begin
      res_r.charge_percent  <= lane_quo[0][PCT_W-1:0];
      res_r.charge_fraction <= div0_rem[FRAC_W-1:0];
    end
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("Result register loaded outside the done state.");

  a_mains_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && main_powered_r) |=> ((state_r == ST_DONE)
      && (res_r.charge_percent == PCT_W'(FULL_SCALE))
      && (res_r.charge_fraction == $past(held_r))))
    else $error("Mains item did not report full scale with the held fraction.");

  a_charge_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r != ST_SUB) && !(cfg_we && (cfg_index == CFG_FULL_CHARGE)))
      |=> $stable(rem_r))
    else $error("Remaining charge changed outside the drain step.");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_coulomb_counting_fuel_gauge_top.sv =====
// ----------------------------------------------------------------------------
// Fuel gauge testbench
// Feeds cumulative activity counter samples to the coulomb-counting gauge and
// predicts every charge reading from its own copy of the gauge state and the
// register settings. Readings are compared field by field in order of arrival.
// The run starts with a short directed part and then moves through random
// register settings with mostly plausible counter streams. Both handshakes
// idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_coulomb_counting_fuel_gauge_top;
  import fg_pkg::*;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int RANDOM_ITEMS = 650;
  localparam logic [CNT_W-1:0] ALL_ONES = '1;

  class charge_scoreboard;
    logic                mains;
    logic [CUR_W-1:0]    cur_cpu, cur_low_power, cur_transmit, cur_listen;
    logic [TPS_W-1:0]    tick_rate;
    logic [PERIOD_W-1:0] period;
    logic [CHARGE_W-1:0] full, remaining;
    logic [FRAC_W-1:0]   held_frac;
    in_item_t            last;
    out_item_t           expected_charge_q[$];
    int                  errors;

    function new();
      mains = 1'b0;
      cur_cpu = '0;
      cur_low_power = '0;
      cur_transmit = '0;
      cur_listen = '0;
      tick_rate = RST_TPS;
      period = RST_PERIOD;
      full = RST_FULL_CHARGE;
      remaining = RST_FULL_CHARGE;
      held_frac = '0;
      last = '0;
      errors = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CHARGE_W-1:0] v);
      case (idx)
        CFG_MAIN_POWERED: mains = v[0];
        CFG_CURRENT_CPU: cur_cpu = v[CUR_W-1:0];
        CFG_CURRENT_LOW_POWER: cur_low_power = v[CUR_W-1:0];
        CFG_CURRENT_TRANSMIT: cur_transmit = v[CUR_W-1:0];
        CFG_CURRENT_LISTEN: cur_listen = v[CUR_W-1:0];
        CFG_TICKS_PER_SECOND: tick_rate = v[TPS_W-1:0];
        CFG_PERIOD_MS: period = v[PERIOD_W-1:0];
        CFG_FULL_CHARGE: begin
          full = v;
          remaining = v;
        end
        default: ;
      endcase
    endfunction

    function logic [63:0] ticks_to_ms(logic [CNT_W-1:0] delta);
      logic [63:0] rate;
      rate = (tick_rate == '0) ? 64'd1 : {43'd0, tick_rate};
      return ({32'd0, delta} * 64'(MS_PER_SECOND)) / rate;
    endfunction

    function void note_sample(in_item_t s);
      logic [63:0]  cpu_ms, lp_ms, tx_ms, ls_ms, slack_limit, busy, drain, per;
      logic [127:0] rest;
      out_item_t    r;
      if (mains) begin
        r.charge_percent = PCT_W'(FULL_SCALE);
        r.charge_fraction = held_frac;
      end else begin
        cpu_ms = ticks_to_ms(s.cpu_ticks - last.cpu_ticks);
        lp_ms = ticks_to_ms(s.low_power_ticks - last.low_power_ticks);
        tx_ms = ticks_to_ms(s.transmit_ticks - last.transmit_ticks);
        ls_ms = ticks_to_ms(s.listen_ticks - last.listen_ticks);
        last = s;
        per = {42'd0, period};
        slack_limit = per + per / 64'(SLACK_DIV);
        // An implausible low-power time is rebuilt from the period.
        if (lp_ms > slack_limit) begin
          busy = cpu_ms + tx_ms + ls_ms;
          lp_ms = (busy >= per) ? 64'd0 : per - busy;
        end
        drain = cpu_ms * cur_cpu + lp_ms * cur_low_power
              + tx_ms * cur_transmit + ls_ms * cur_listen;
        remaining = (drain >= {16'd0, remaining}) ? '0 : remaining - drain[CHARGE_W-1:0];
        if (full == '0) begin
          r = '0;
          held_frac = '0;
        end else begin
          rest = ({80'd0, remaining} * 128'(SCALE)) / {80'd0, full};
          if (rest > 128'(SCALE)) rest = 128'(SCALE);
          held_frac = FRAC_W'(rest % 128'(FS_EFF));
          r.charge_percent = PCT_W'(rest / 128'(FS_EFF));
          r.charge_fraction = held_frac;
        end
      end
      expected_charge_q.push_back(r);
    endfunction

    function void check_reading(out_item_t got);
      out_item_t want;
      if (expected_charge_q.size() == 0) begin
        $error("charge reading with none expected: percent %0d, fraction %0d",
               got.charge_percent, got.charge_fraction);
        errors++;
        return;
      end
      want = expected_charge_q.pop_front();
      if (got.charge_percent !== want.charge_percent) begin
        $error("charge_percent: expected %0d, actual %0d",
               want.charge_percent, got.charge_percent);
        errors++;
      end
      if (got.charge_fraction !== want.charge_fraction) begin
        $error("charge_fraction: expected %0d, actual %0d",
               want.charge_fraction, got.charge_fraction);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                cfg_we;
  cfg_idx_t            cfg_index;
  logic [CHARGE_W-1:0] cfg_wdata;

  int                  cycles = 0;
  int                  burst_left;
  logic [1:0]          ready_mode = 2'd0;
  in_item_t            counts;
  charge_scoreboard    sb;

  coulomb_counting_fuel_gauge_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid && out_ready) sb.check_reading(out_data);
    if (cycles[6:0] == 7'h7F) ready_mode <= 2'($urandom_range(0, 2));
    case (ready_mode)
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= (cycles[3:0] >= 4'd10);
    endcase
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_sample(input in_item_t s);
    in_valid <= 1'b1;
    in_data <= s;
    counts = s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_sample(s);
  endtask

  task automatic set_reg(input cfg_idx_t idx, input logic [CHARGE_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.expected_charge_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [CUR_W-1:0] pick_current();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return CUR_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Most samples split one period of ticks over the four modes; some carry an
  // inflated low-power count and a few are arbitrary counter values.
  function automatic in_item_t next_sample();
    logic [63:0] span, cpu_d, tx_d, ls_d, lp_d;
    int          kind;
    in_item_t    s;
    kind = $urandom_range(0, 99);
    span = 64'(sb.period) * ((sb.tick_rate == '0) ? 64'd1 : 64'(sb.tick_rate)) / 64'd1000;
    if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
    cpu_d = span * $urandom_range(0, 30) / 100 + $urandom_range(0, 3);
    tx_d = span * $urandom_range(0, 10) / 100 + $urandom_range(0, 3);
    ls_d = span * $urandom_range(0, 20) / 100 + $urandom_range(0, 3);
    lp_d = span - cpu_d - tx_d - ls_d + $urandom_range(0, 3);
    if (kind < 12) lp_d = span * $urandom_range(112, 400) / 100 + $urandom_range(1, 5000);
    s.cpu_ticks = counts.cpu_ticks + cpu_d[31:0];
    s.low_power_ticks = counts.low_power_ticks + lp_d[31:0];
    s.transmit_ticks = counts.transmit_ticks + tx_d[31:0];
    s.listen_ticks = counts.listen_ticks + ls_d[31:0];
    if (kind >= 94) s = {$urandom, $urandom, $urandom, $urandom};
    return s;
  endfunction

  task automatic send_items(input int n);
    for (int i = 0; i < n; i++) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat (($urandom_range(0, 9) == 0) ? $urandom_range(40, 260) : $urandom_range(1, 8))
          @(posedge clk);
        burst_left = $urandom_range(1, 12);
      end
      send_sample(next_sample());
      burst_left--;
    end
  endtask

  task automatic random_setting();
    logic [63:0]         hi;
    logic [63:0]         est;
    logic [TPS_W-1:0]    rate;
    logic [PERIOD_W-1:0] per;
    logic [CHARGE_W-1:0] full;
    hi = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'd0;
    set_reg(CFG_MAIN_POWERED, {hi[47:1], ($urandom_range(0, 99) < 15)});
    if ($urandom_range(0, 1)) set_reg(CFG_CURRENT_CPU, {hi[47:16], pick_current()});
    if ($urandom_range(0, 1)) set_reg(CFG_CURRENT_LOW_POWER, {hi[47:16], pick_current()});
    if ($urandom_range(0, 1)) set_reg(CFG_CURRENT_TRANSMIT, {hi[47:16], pick_current()});
    if ($urandom_range(0, 1)) set_reg(CFG_CURRENT_LISTEN, {hi[47:16], pick_current()});
    if ($urandom_range(0, 2) == 0) begin
      case ($urandom_range(0, 7))
        0: rate = 21'd1;
        1: rate = 21'd1048576;
        2: rate = '1;
        3: rate = '0;
        4, 5: rate = 21'd32768;
        default: rate = TPS_W'($urandom_range(1, 1048576));
      endcase
      set_reg(CFG_TICKS_PER_SECOND, {hi[47:21], rate});
    end
    if ($urandom_range(0, 2) == 0) begin
      case ($urandom_range(0, 7))
        0: per = 22'd1;
        1: per = 22'd3600000;
        2: per = '1;
        3: per = '0;
        4, 5: per = 22'd60000;
        default: per = PERIOD_W'($urandom_range(1000, 600000));
      endcase
      set_reg(CFG_PERIOD_MS, {hi[47:22], per});
    end
    est = 64'(sb.period) * (64'(sb.cur_cpu) + 64'(sb.cur_low_power)
          + 64'(sb.cur_transmit) + 64'(sb.cur_listen)) + 64'd1;
    if (sb.remaining == '0 || $urandom_range(0, 1)) begin
      case ($urandom_range(0, 11))
        0: full = '1;
        1: full = CHARGE_W'($urandom_range(1, 1000));
        2: full = '0;
        3: full = CHARGE_W'({$urandom, $urandom});
        default: full = CHARGE_W'(est * $urandom_range(2, 60));
      endcase
      set_reg(CFG_FULL_CHARGE, full);
    end
  endtask

  initial begin
    int sent;
    int n;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_MAIN_POWERED;
    cfg_wdata = '0;
    burst_left = 0;
    counts = '0;
    sent = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // With reset settings no current is drawn, so the gauge reads full scale.
    send_sample('0);
    send_sample({4{ALL_ONES}});
    wait_idle();
    set_reg(CFG_CURRENT_CPU, 48'hFFFF);
    set_reg(CFG_CURRENT_LOW_POWER, 48'hFFFF);
    set_reg(CFG_CURRENT_TRANSMIT, 48'hFFFF);
    set_reg(CFG_CURRENT_LISTEN, 48'hFFFF);
    set_reg(CFG_TICKS_PER_SECOND, 48'd1);
    set_reg(CFG_PERIOD_MS, 48'd3600000);
    set_reg(CFG_FULL_CHARGE, '1);
    send_sample('0);
    send_sample(in_item_t'{32'd1, 32'd10_000_000, 32'd1, 32'd1});
    send_sample({4{ALL_ONES}});
    wait_idle();
    set_reg(CFG_CURRENT_CPU, 48'd1);
    set_reg(CFG_CURRENT_LOW_POWER, 48'd0);
    set_reg(CFG_CURRENT_TRANSMIT, 48'd0);
    set_reg(CFG_CURRENT_LISTEN, 48'd0);
    set_reg(CFG_TICKS_PER_SECOND, 48'd1000);
    set_reg(CFG_FULL_CHARGE, 48'd3);
    send_sample(in_item_t'{32'd0, ALL_ONES, ALL_ONES, ALL_ONES});
    wait_idle();
    set_reg(CFG_MAIN_POWERED, 48'd1);
    send_sample({$urandom, $urandom, $urandom, $urandom});
    send_sample('0);
    wait_idle();
    set_reg(CFG_MAIN_POWERED, 48'd0);
    send_sample(in_item_t'{32'd0, ALL_ONES, ALL_ONES, ALL_ONES});
    wait_idle();
    set_reg(CFG_FULL_CHARGE, 48'd0);
    send_sample(in_item_t'{32'd0, ALL_ONES, ALL_ONES, ALL_ONES});
    wait_idle();
    set_reg(CFG_MAIN_POWERED, 48'd1);
    send_sample(in_item_t'{32'd5, 32'd6, 32'd7, 32'd8});
    wait_idle();
    set_reg(CFG_MAIN_POWERED, 48'd0);
    set_reg(CFG_TICKS_PER_SECOND, 48'd0);
    set_reg(CFG_PERIOD_MS, 48'd0);
    set_reg(CFG_CURRENT_LOW_POWER, 48'd7);
    set_reg(CFG_FULL_CHARGE, 48'd50_000_000);
    send_sample(in_item_t'{32'd2, 32'd3, 32'd1, 32'd1});
    wait_idle();
    set_reg(CFG_TICKS_PER_SECOND, 48'h1F_FFFF);
    set_reg(CFG_PERIOD_MS, 48'h3F_FFFF);
    send_sample({$urandom, $urandom, $urandom, $urandom});
    send_sample({$urandom, $urandom, $urandom, $urandom});

    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      random_setting();
      n = $urandom_range(10, 60);
      send_items(n);
      sent += n;
    end

    in_valid <= 1'b0;
    while (sb.expected_charge_q.size() != 0) @(posedge clk);
    repeat (256) @(posedge clk);
    if (sb.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
